FILE: src/ihd_pkg.sv
// ----------------------------------------------------------------------------
// ihd_pkg: shared constants, coefficient tables and types
// Fixed-point formats, history memory geometry and the control/status
// structs that pass between the sequencer and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ihd_pkg;

  // Number of filter taps; the legal range is 2 to 16.
  localparam int TAP_COUNT = 12;

  localparam int TapMax    = 16;
  localparam int TapsUsed  = (TAP_COUNT > TapMax) ? TapMax : ((TAP_COUNT < 2) ? 2 : TAP_COUNT);
  localparam int HistDepth = 1 << $clog2(TapsUsed);
  localparam int AddrW     = $clog2(HistDepth);
  localparam int CoefIdxW  = $clog2(TapMax);

  localparam int SampleW   = 24;
  localparam int HistW     = 32;
  localparam int CoefW     = 32;
  localparam int AccW      = 64;
  localparam int CoefFrac  = 26;
  localparam int FfProdW   = CoefW + SampleW;
  localparam int FbProdW   = CoefW + HistW;

  // Feed-forward taps, Q6.26. Taps past the twelfth are zero.
  localparam logic signed [CoefW-1:0] FfCoef [TapMax] = '{
    32'sd159192,  32'sd719141,  32'sd2037285, 32'sd4073797,
    32'sd6313472, 32'sd7796528, 32'sd7796528, 32'sd6313472,
    32'sd4073797, 32'sd2037285, 32'sd719141,  32'sd159192,
    32'sd0,       32'sd0,       32'sd0,       32'sd0
  };

  // Feedback taps, Q6.26. The zero-delay feedback tap is zero.
  localparam logic signed [CoefW-1:0] FbCoef [TapMax] = '{
    32'sd0,          -32'sd216469105, 32'sd532660960,  -32'sd896682079,
    32'sd1218745870, -32'sd1312754080, 32'sd1158571253, -32'sd825224675,
    32'sd469056287,  -32'sd204256553, 32'sd62575560,   -32'sd11133470,
    32'sd0,          32'sd0,          32'sd0,          32'sd0
  };

  typedef struct packed {
    logic             acc_clr;  // start a new sum
    logic             rd_vld;   // history read issued this cycle
    logic [AddrW-1:0] tap;      // tap index of that read
  } ihd_mac_ctl_t;

  typedef struct packed {
    logic             busy;     // products still in flight
    logic [HistW-1:0] y;        // rounded, saturated filter output
  } ihd_mac_st_t;

endpackage

`default_nettype wire

FILE: src/ihd_if.sv
// ----------------------------------------------------------------------------
// ihd_if: stream channels of the decimator
// Sample-pair input channel and filtered-result output channel, each with a
// valid/ready handshake and source/sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihd_pair_if import ihd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_first;
  logic signed [SampleW-1:0] sample_second;

  modport source (output valid, output sample_first, output sample_second, input ready);
  modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

interface ihd_result_if import ihd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] filtered_sample;

  modport source (output valid, output filtered_sample, input ready);
  modport sink   (input valid, input filtered_sample, output ready);
endinterface

`default_nettype wire

FILE: src/ihd_ram.sv
// ----------------------------------------------------------------------------
// ihd_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ihd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/ihd_mac.sv
// ----------------------------------------------------------------------------
// ihd_mac: multiply-accumulate unit of the decimator
// Multiplies the history words read from memory by their taps, sums them in
// a 64-bit accumulator and rounds and saturates the sum to a history word.
// ----------------------------------------------------------------------------
`default_nettype none

module ihd_mac import ihd_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ihd_mac_ctl_t              ctl_i,
  input  wire logic signed [SampleW-1:0] in_hist_i,
  input  wire logic signed [HistW-1:0]   out_hist_i,
  output ihd_mac_st_t                    st_o
);

  localparam int ShW = AccW - CoefFrac;
  localparam logic [AccW-1:0] RoundBias = AccW'(1) << (CoefFrac - 1);

  logic                        rd_v_q;
  logic [AddrW-1:0]            tap_q;
  logic                        prod_v_q;
  logic signed [FfProdW-1:0]   prod_ff_d, prod_ff_q;
  logic signed [FbProdW-1:0]   prod_fb_d, prod_fb_q;
  logic [AccW-1:0]             acc_d, acc_q;
  logic [AccW-1:0]             rnd;
  logic [ShW-1:0]              sh;
  logic                        fits;

  // The registered read data lines up with the registered tap index.
  assign prod_ff_d = FfCoef[CoefIdxW'(tap_q)] * in_hist_i;
  assign prod_fb_d = FbCoef[CoefIdxW'(tap_q)] * out_hist_i;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_clr) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + AccW'(prod_ff_q) - AccW'(prod_fb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= ctl_i.rd_vld;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q     <= ctl_i.tap;
    prod_ff_q <= prod_ff_d;
    prod_fb_q <= prod_fb_d;
    acc_q     <= acc_d;
  end

  // Round half up, drop the coefficient fraction and saturate to 32 bits.
  assign rnd  = acc_q + RoundBias;
  assign sh   = rnd[AccW-1:CoefFrac];
  assign fits = (&sh[ShW-1:HistW-1]) | ~(|sh[ShW-1:HistW-1]);

  always_comb begin
    st_o.busy = rd_v_q | prod_v_q;
    if (fits) begin
      st_o.y = sh[HistW-1:0];
    end else if (sh[ShW-1]) begin
      st_o.y = {1'b1, {(HistW-1){1'b0}}};
    end else begin
      st_o.y = {1'b0, {(HistW-1){1'b1}}};
    end
  end

  a_prod_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> $past(rd_v_q))
    else $error("product marked valid without a read one cycle before");

  a_clear_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.acc_clr |-> !st_o.busy)
    else $error("accumulator cleared while products are in flight");

endmodule

`default_nettype wire

FILE: src/iir_halfband_decimator.sv
// ----------------------------------------------------------------------------
// iir_halfband_decimator: elliptic IIR low-pass with decimation by two
// Filters a pair of oversampled samples and returns one output per pair.
// ----------------------------------------------------------------------------
// Usage: the source offers a word with two signed 24-bit samples on pair_i;
// the earlier sample is filtered first. One word of one filtered, saturated
// 24-bit sample leaves on result_o for every accepted pair.
// Each sample is stored in the input history memory, its taps are read one a
// cycle from both history memories, the multiply and accumulate pipeline
// empties and the rounded sum is written as the new output history entry.
// A new pair is accepted only after both samples are through and the result
// has gone to the output register; the pace is set by the single read port
// of each history memory.
// After reset the block writes zeros to all 16 entries of both history
// memories and only then raises pair_i.ready.
// The output register lets a new pair be accepted while an earlier result is
// still waiting. If result_o is stalled when the next result is ready, the
// block holds that result internally and takes no new pair until the
// receiver takes the waiting word.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_halfband_decimator import ihd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ihd_pair_if.sink      pair_i,
  ihd_result_if.source  result_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,  // zero both history memories
    ST_IDLE,   // wait for a sample pair
    ST_LOAD,   // write the current sample into the input history
    ST_MAC,    // read one tap per cycle
    ST_DRAIN,  // let the multiply-accumulate pipeline empty
    ST_ROUND,  // write the new output history entry
    ST_DONE    // hand the result to the output register
  } state_e;

  localparam logic [AddrW-1:0] LastTap  = AddrW'(TapsUsed - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(HistDepth - 1);

  state_e                    state_q;
  logic [AddrW-1:0]          ptr_q;
  logic [AddrW-1:0]          tap_q;
  logic                      second_q;
  logic signed [SampleW-1:0] first_q, later_q;
  logic                      out_vld_q;
  logic signed [SampleW-1:0] out_data_q;

  logic                      ih_we, oh_we;
  logic [AddrW-1:0]          ih_waddr, raddr;
  logic signed [SampleW-1:0] ih_wdata, ih_rdata;
  logic signed [HistW-1:0]   oh_wdata, oh_rdata;
  ihd_mac_ctl_t              mac_ctl;
  ihd_mac_st_t               mac_st;
  logic signed [SampleW-1:0] y_sat;
  logic                      y_fits;
  logic                      out_load;

  // The history memories are circular buffers sharing one head pointer: the
  // sample and the output of the same time step live at the same address, so
  // the tap k of either history sits k entries behind the head.
  assign ih_we    = (state_q == ST_CLEAR) || (state_q == ST_LOAD);
  assign ih_waddr = (state_q == ST_CLEAR) ? ptr_q : ptr_q + 1'b1;
  assign ih_wdata = (state_q == ST_CLEAR) ? '0 : (second_q ? later_q : first_q);
  assign oh_we    = (state_q == ST_CLEAR) || (state_q == ST_ROUND);
  assign oh_wdata = (state_q == ST_CLEAR) ? '0 : mac_st.y;
  assign raddr    = ptr_q - tap_q;

  ihd_ram #(.Width(SampleW), .Depth(HistDepth)) u_in_hist (
    .clk_i   (clk_i),
    .we_i    (ih_we),
    .waddr_i (ih_waddr),
    .wdata_i (ih_wdata),
    .raddr_i (raddr),
    .rdata_o (ih_rdata)
  );

  ihd_ram #(.Width(HistW), .Depth(HistDepth)) u_out_hist (
    .clk_i   (clk_i),
    .we_i    (oh_we),
    .waddr_i (ptr_q),
    .wdata_i (oh_wdata),
    .raddr_i (raddr),
    .rdata_o (oh_rdata)
  );

  assign mac_ctl.acc_clr = (state_q == ST_LOAD);
  assign mac_ctl.rd_vld  = (state_q == ST_MAC);
  assign mac_ctl.tap     = tap_q;

  ihd_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .in_hist_i  (ih_rdata),
    .out_hist_i (oh_rdata),
    .st_o       (mac_st)
  );

  // The history keeps 32 bits; the result word is saturated to 24 bits.
  assign y_fits = (&mac_st.y[HistW-1:SampleW-1]) | ~(|mac_st.y[HistW-1:SampleW-1]);
  always_comb begin
    if (y_fits) begin
      y_sat = mac_st.y[SampleW-1:0];
    end else if (mac_st.y[HistW-1]) begin
      y_sat = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  // The output register takes a new word when it is empty or its word is
  // leaving in the same cycle.
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || result_o.ready);

  assign pair_i.ready             = (state_q == ST_IDLE);
  assign result_o.valid           = out_vld_q;
  assign result_o.filtered_sample = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ptr_q      <= '0;
      tap_q      <= '0;
      second_q   <= 1'b0;
      first_q    <= '0;
      later_q    <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (out_load) begin
        out_vld_q  <= 1'b1;
        out_data_q <= y_sat;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LastAddr) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pair_i.valid) begin
            first_q  <= pair_i.sample_first;
            later_q  <= pair_i.sample_second;
            second_q <= 1'b0;
            state_q  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ptr_q   <= ptr_q + 1'b1;
          tap_q   <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (tap_q == LastTap) begin
            state_q <= ST_DRAIN;
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!mac_st.busy) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (second_q) begin
            state_q <= ST_DONE;
          end else begin
            second_q <= 1'b1;
            state_q  <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_round_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> !mac_st.busy)
    else $error("output written back before the accumulator settled");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_DONE)
    else $error("result word raised outside the hand-off state");

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> tap_q <= LastTap)
    else $error("tap index beyond the last tap");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the elliptic IIR decimate-by-two filter
// Sample-pair words are driven from a queue and every filtered word is
// compared with a bit-exact fixed-point predictor of the filter history.
// ----------------------------------------------------------------------------

module tb;
  import ihd_pkg::*;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t first;
    sample_t second;
  } sample_pair_t;

  // Filter geometry and coefficients, Q6.26. The zero-delay feedback tap is
  // zero, so the newest output never feeds its own sum.
  localparam int Taps = 12;
  localparam int CoefShift = 26;
  localparam int CycleLimit = 500000;
  localparam int RandomPerPhase = 332;
  localparam int PhaseCount = 4;
  localparam longint HistMax = 64'sh0000_0000_7fff_ffff;
  localparam longint HistMin = -HistMax - 1;
  localparam sample_t SampleMax = 24'sh7f_ffff;
  localparam sample_t SampleMin = 24'sh80_0000;

  localparam int FfTaps [Taps] = '{
    159192, 719141, 2037285, 4073797, 6313472, 7796528,
    7796528, 6313472, 4073797, 2037285, 719141, 159192
  };
  localparam int FbTaps [Taps] = '{
    0, -216469105, 532660960, -896682079, 1218745870, -1312754080,
    1158571253, -825224675, 469056287, -204256553, 62575560, -11133470
  };

  logic clk;
  logic rst_n;

  ihd_pair_if   pair_ch ();
  ihd_result_if res_ch ();

  iir_halfband_decimator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pair_i  (pair_ch),
    .result_o(res_ch)
  );

  // Filter history of the predictor, cleared once like the block at reset.
  sample_t x_hist [Taps] = '{default: '0};
  int      y_hist [Taps] = '{default: 0};

  sample_pair_t pending_pairs [$];
  sample_t      expected_outputs [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  logic pair_taken = 1'b0;
  int cycle_count = 0;
  int fail_count = 0;
  int pairs_accepted = 0;
  int results_checked = 0;
  int clamped_outputs = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One sample through the direct-form-I filter. The 64-bit sum wraps like
  // the hardware accumulator; the new output is rounded half up, then
  // clamped to 32 bits before it enters the output history.
  task automatic filter_sample(input sample_t x);
    longint acc;
    acc = 0;
    for (int j = Taps - 1; j > 0; j--) begin
      x_hist[j] = x_hist[j-1];
      y_hist[j] = y_hist[j-1];
    end
    x_hist[0] = x;
    for (int j = 0; j < Taps; j++) begin
      acc += longint'(FfTaps[j]) * longint'(x_hist[j]);
    end
    for (int j = 0; j < Taps; j++) begin
      acc -= longint'(FbTaps[j]) * longint'(y_hist[j]);
    end
    acc += longint'(1) <<< (CoefShift - 1);
    acc = acc >>> CoefShift;
    if (acc > HistMax) begin
      y_hist[0] = int'(HistMax);
    end else if (acc < HistMin) begin
      y_hist[0] = int'(HistMin);
    end else begin
      y_hist[0] = int'(acc);
    end
  endtask

  // Both samples go through the filter; only the second output is kept,
  // clamped to the 24-bit sample range.
  task automatic decimate_pair(input sample_t first, input sample_t second,
                               output sample_t y);
    filter_sample(first);
    filter_sample(second);
    if (y_hist[0] > int'(SampleMax)) begin
      y = SampleMax;
      clamped_outputs++;
    end else if (y_hist[0] < int'(SampleMin)) begin
      y = SampleMin;
      clamped_outputs++;
    end else begin
      y = sample_t'(y_hist[0]);
    end
  endtask

  task automatic queue_pair(input sample_t first, input sample_t second);
    sample_pair_t pair_word;
    pair_word.first = first;
    pair_word.second = second;
    pending_pairs.insert(pending_pairs.size(), pair_word);
  endtask

  // Random traffic: full-range noise, small signals, held levels that ring
  // the filter (and drive it into the clamp), and alternating extremes at
  // the top of the band.
  task automatic queue_random(input int n);
    int left;
    int kind;
    int run;
    sample_t level;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        queue_pair(sample_t'($urandom()), sample_t'($urandom()));
        left--;
      end else if (kind < 65) begin
        queue_pair(sample_t'(int'($urandom_range(131071)) - 65536),
                   sample_t'(int'($urandom_range(131071)) - 65536));
        left--;
      end else if (kind < 85) begin
        case ($urandom_range(3))
          0: level = SampleMax;
          1: level = SampleMin;
          2: level = sample_t'($urandom());
          default: level = '0;
        endcase
        run = $urandom_range(4, 24);
        while (run > 0 && left > 0) begin
          queue_pair(level, level);
          run--;
          left--;
        end
      end else begin
        run = $urandom_range(2, 10);
        while (run > 0 && left > 0) begin
          if (kind[0]) queue_pair(SampleMax, SampleMin);
          else queue_pair(SampleMin, SampleMax);
          run--;
          left--;
        end
      end
    end
  endtask

  // Driver: a new word goes out at the falling edge once the previous one
  // was taken, unless the sender decides to idle this cycle.
  always @(negedge clk) begin
    sample_pair_t next_pair;
    if (!rst_n) begin
      pair_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      if (!pair_ch.valid || pair_taken) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_pair = pending_pairs.pop_front();
          pair_ch.valid <= 1'b1;
          pair_ch.sample_first <= next_pair.first;
          pair_ch.sample_second <= next_pair.second;
        end else begin
          pair_ch.valid <= 1'b0;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: accepted pairs feed the predictor, accepted results are checked
  // against the oldest prediction.
  always @(posedge clk) begin
    sample_t y;
    sample_t want;
    if (!rst_n) begin
      pair_taken <= 1'b0;
    end else begin
      pair_taken <= pair_ch.valid && pair_ch.ready;
      if (pair_ch.valid && pair_ch.ready) begin
        decimate_pair(pair_ch.sample_first, pair_ch.sample_second, y);
        expected_outputs.insert(expected_outputs.size(), y);
        pairs_accepted++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_outputs.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result word: filtered_sample %0d", res_ch.filtered_sample);
          end
          fail_count++;
        end else begin
          want = expected_outputs.pop_front();
          results_checked++;
          if (res_ch.filtered_sample !== want) begin
            if (fail_count < 10) begin
              $display("mismatch on filtered_sample (result %0d): expected %0d, got %0d",
                       results_checked, want, res_ch.filtered_sample);
            end
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_outputs.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Stimulus sequence. Phase 0 runs without idling and carries the directed
  // words; later phases add sender gaps, receiver stalls, then both. Between
  // phases the sender holds off until every expected word has come back.
  initial begin
    rst_n = 1'b0;
    pair_ch.valid = 1'b0;
    pair_ch.sample_first = '0;
    pair_ch.sample_second = '0;
    res_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      @(posedge clk);
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
        default: begin src_idle_pct = 15; snk_stall_pct = 15; end
      endcase
      if (phase == 0) begin
        queue_pair('0, '0);
        // A full-scale step rings past the top of the range and saturates.
        repeat (10) queue_pair(SampleMax, SampleMax);
        // A full negative swing drives the history the other way.
        repeat (6) queue_pair(SampleMin, SampleMin);
        queue_pair(SampleMax, SampleMin);
        queue_pair(SampleMin, SampleMax);
        queue_pair(24'sd1, -24'sd1);
        queue_pair(-24'sd1, 24'sd1);
        queue_pair('0, '0);
      end
      queue_random(RandomPerPhase);
      do begin
        @(negedge clk);
      end while (pending_pairs.size() != 0 || pair_ch.valid ||
                 expected_outputs.size() != 0);
    end

    // Catch any stray word the block might still send.
    repeat (64) @(posedge clk);
    if (expected_outputs.size() != 0) begin
      $display("%0d expected results never arrived", expected_outputs.size());
      fail_count++;
    end

    $display("Filtered %0d sample pairs across four flow-control phases; %0d results checked.",
             pairs_accepted, results_checked);
    $display("%0d outputs hit the 24-bit clamp; %0d failures seen.",
             clamped_outputs, fail_count);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
